// ----- hdl/swfr_pkg.sv -----
`default_nettype none

package swfr_pkg;

	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int IDX_W  = 5;

	localparam logic [WORD_W-1:0] START_RESET = 16'hABCD;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_CSUM_ERR = 1'b1;

	typedef struct packed {
		logic              status;
		logic              last;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] value;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/sync_word_frame_receiver.sv -----
`default_nettype none

// Sync-word frame receiver. Bytes enter on s_* one per beat, one beat a cycle while a frame
// fills. When the low/high byte pair matches start_word a frame (re)starts; once FRAME_BYTES
// bytes are held, the frame is checked against the XOR of its first FRAME_BYTES/2-1 words,
// which is accumulated as the bytes arrive. The frame sits in two byte-wide banks (even and
// odd bytes), so after the last byte of a frame the input is held off through a check state
// and while the words are read out, one word per cycle unless m_tready stalls (for a checksum
// error, only until the error beat is queued). A bad frame gives a single beat with
// tuser set, zero data and tlast. The config channel is always ready.
module sync_word_frame_receiver #(
	parameter int FRAME_BYTES = 56
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] cfg_data,   // start_word
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,    // rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,    // word_index[4:0], word_value[20:5], zero[23:21]
	output logic [0:0]  m_tuser,    // status
	output logic        m_tlast     // last
);

	localparam int BW          = swfr_pkg::BYTE_W;
	localparam int WW          = swfr_pkg::WORD_W;
	localparam int IW          = swfr_pkg::IDX_W;
	localparam int FRAME_WORDS = FRAME_BYTES / 2;
	localparam int BANK_DEPTH  = (FRAME_BYTES + 1) / 2;
	localparam int AW          = $clog2(BANK_DEPTH);
	localparam int CW          = $clog2(FRAME_BYTES + 1);
	localparam int RCW         = $clog2(FRAME_WORDS + 1);
	localparam int LAST_LO     = 2 * (FRAME_WORDS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_EMIT, ST_ERR} state_t;

	state_t               state_q;
	logic [WW-1:0]        start_word_q;
	logic [BW-1:0]        prev_q;
	logic [CW-1:0]        count_q;
	logic [BW-1:0]        acc_lo_q, acc_hi_q;
	logic [BW-1:0]        last_lo_q, last_hi_q;
	logic [RCW-1:0]       rd_cnt_q;

	logic [BW-1:0]        bank_even [BANK_DEPTH];
	logic [BW-1:0]        bank_odd  [BANK_DEPTH];
	logic [BW-1:0]        rd_lo_q, rd_hi_q;

	logic                 s1_valid_q;
	logic                 s1_err_s1;
	logic                 s1_last_s1;
	logic [IW-1:0]        s1_idx_s1;

	logic                 out_valid_q;
	swfr_pkg::result_t    out_q;

	logic                 accept, is_start, is_append, frame_done;
	logic                 load_out, s1_free, rd_en, rd_last;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic [WW-1:0]        s1_value;

	assign cfg_ready  = 1'b1;
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign is_start   = accept && ({s_tdata, prev_q} == start_word_q);
	assign is_append  = accept && !is_start && (count_q >= CW'(2));
	assign frame_done = is_append && (count_q == CW'(FRAME_BYTES - 1));
	assign wr_addr    = count_q[AW:1];

	assign load_out = s1_valid_q && (!out_valid_q || m_tready);
	assign s1_free  = !s1_valid_q || load_out;
	assign rd_en    = (state_q == ST_EMIT) && s1_free;
	assign rd_addr  = rd_cnt_q[AW-1:0];
	assign rd_last  = (rd_cnt_q == RCW'(FRAME_WORDS - 1));
	assign s1_value = s1_err_s1 ? '0 : {rd_hi_q, rd_lo_q};

	always_ff @(posedge clk) begin
		if (is_start) begin
			bank_even[0] <= prev_q;
			bank_odd[0]  <= s_tdata;
		end else if (is_append) begin
			if (count_q[0]) begin
				bank_odd[wr_addr] <= s_tdata;
			end else begin
				bank_even[wr_addr] <= s_tdata;
			end
		end
		if (rd_en) begin
			rd_lo_q <= bank_even[rd_addr];
			rd_hi_q <= bank_odd[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			start_word_q <= swfr_pkg::START_RESET;
			prev_q       <= '0;
			count_q      <= '0;
			acc_lo_q     <= '0;
			acc_hi_q     <= '0;
			last_lo_q    <= '0;
			last_hi_q    <= '0;
			rd_cnt_q     <= '0;
			s1_valid_q   <= 1'b0;
			s1_err_s1    <= 1'b0;
			s1_last_s1   <= 1'b0;
			s1_idx_s1    <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_valid) begin
				start_word_q <= cfg_data;
			end
			if (accept) begin
				prev_q <= s_tdata;
			end
			if (is_start) begin
				count_q  <= CW'(2);
				acc_lo_q <= prev_q;
				acc_hi_q <= s_tdata;
			end else if (is_append) begin
				count_q <= frame_done ? '0 : count_q + CW'(1);
				if (count_q < CW'(LAST_LO)) begin
					if (count_q[0]) begin
						acc_hi_q <= acc_hi_q ^ s_tdata;
					end else begin
						acc_lo_q <= acc_lo_q ^ s_tdata;
					end
				end
				if (count_q == CW'(LAST_LO)) begin
					last_lo_q <= s_tdata;
				end
				if (count_q == CW'(LAST_LO + 1)) begin
					last_hi_q <= s_tdata;
				end
			end

			if (load_out) begin
				s1_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (frame_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					rd_cnt_q <= '0;
					if ({acc_hi_q, acc_lo_q} == {last_hi_q, last_lo_q}) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_ERR;
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						s1_valid_q <= 1'b1;
						s1_err_s1  <= swfr_pkg::STATUS_OK;
						s1_idx_s1  <= IW'(rd_addr);
						s1_last_s1 <= rd_last;
						rd_cnt_q   <= rd_cnt_q + RCW'(1);
						if (rd_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (s1_free) begin
						s1_valid_q <= 1'b1;
						s1_err_s1  <= swfr_pkg::STATUS_CSUM_ERR;
						s1_idx_s1  <= '0;
						s1_last_s1 <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (load_out) begin
				out_valid_q  <= 1'b1;
				out_q.status <= s1_err_s1;
				out_q.last   <= s1_last_s1;
				out_q.idx    <= s1_idx_s1;
				out_q.value  <= s1_value;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.value, out_q.idx};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

`ifndef SYNTH
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == swfr_pkg::STATUS_CSUM_ERR) |-> m_tlast && (m_tdata == '0))
		else $error("checksum error beat malformed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(FRAME_BYTES))
		else $error("fill count reached frame length");

	a_read_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (!s1_valid_q || load_out))
		else $error("memory read would overwrite pending word");

	a_done_check: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> (state_q == ST_CHECK) && (count_q == '0))
		else $error("completed frame not checked");
`endif

endmodule

`default_nettype wire

// ----- test/sync_word_frame_receiver_tb.sv -----
`timescale 1ns / 1ps

module sync_word_frame_receiver_tb;

	localparam int FRAME_BYTES = 56;
	localparam int FRAME_WORDS = FRAME_BYTES / 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	// frame receiver state as predicted
	logic [swfr_pkg::WORD_W-1:0] sync_word;
	logic [7:0]                  held_byte;
	int                          fill_level;
	logic [7:0]                  frame_bytes [64];
	swfr_pkg::result_t           expected_words [$];

	int  mismatches;
	int  cycle_count;
	int  stall_left;
	bit  tx_idle_on;
	bit  rx_idle_on;

	sync_word_frame_receiver #(
		.FRAME_BYTES(FRAME_BYTES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [swfr_pkg::WORD_W-1:0] word_of(input int w);
		return {frame_bytes[2 * w + 1], frame_bytes[2 * w]};
	endfunction

	task automatic absorb_byte(input logic [7:0] b);
		logic [swfr_pkg::WORD_W-1:0] pair_w;
		logic [swfr_pkg::WORD_W-1:0] csum;
		swfr_pkg::result_t           r;
		int                          i;
		pair_w = {b, held_byte};
		if (pair_w == sync_word) begin
			frame_bytes[0] = held_byte;
			frame_bytes[1] = b;
			fill_level = 2;
		end else if (fill_level >= 2 && fill_level < FRAME_BYTES) begin
			frame_bytes[fill_level] = b;
			fill_level++;
		end
		held_byte = b;
		if (fill_level == FRAME_BYTES) begin
			fill_level = 0;
			csum = '0;
			for (i = 0; i < FRAME_WORDS - 1; i++)
				csum ^= word_of(i);
			if (csum != word_of(FRAME_WORDS - 1)) begin
				r.status = swfr_pkg::STATUS_CSUM_ERR;
				r.last = 1'b1;
				r.idx = '0;
				r.value = '0;
				expected_words.push_back(r);
			end else begin
				for (i = 0; i < FRAME_WORDS; i++) begin
					r.status = swfr_pkg::STATUS_OK;
					r.last = (i == FRAME_WORDS - 1);
					r.idx = i[swfr_pkg::IDX_W-1:0];
					r.value = word_of(i);
					expected_words.push_back(r);
				end
			end
		end
	endtask

	always @(posedge clk) begin : check_words
		swfr_pkg::result_t got;
		swfr_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser[0];
			got.last = m_tlast;
			got.idx = m_tdata[4:0];
			got.value = m_tdata[20:5];
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: status=%0d idx=%0d value=%h last=%0d",
						got.status, got.idx, got.value, got.last);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp status=%0d idx=%0d value=%h last=%0d,",
							" got status=%0d idx=%0d value=%h last=%0d"},
							want.status, want.idx, want.value, want.last,
							got.status, got.idx, got.value, got.last);
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		absorb_byte(b);
	endtask

	// abandon_len >= 0 opens a frame of that many extra bytes first, then restarts
	task automatic send_frame(input bit good, input bit extreme, input int abandon_len);
		logic [swfr_pkg::WORD_W-1:0] words [FRAME_WORDS];
		logic [swfr_pkg::WORD_W-1:0] csum;
		int                          i;
		if (abandon_len >= 0) begin
			send_byte(sync_word[7:0]);
			send_byte(sync_word[15:8]);
			for (i = 0; i < abandon_len; i++)
				send_byte(8'($urandom_range(0, 255)));
		end
		words[0] = sync_word;
		csum = sync_word;
		for (i = 1; i < FRAME_WORDS - 1; i++) begin
			if (extreme)
				words[i] = i[0] ? 16'hFFFF : 16'h0000;
			else
				words[i] = 16'($urandom_range(0, 65535));
			csum ^= words[i];
		end
		words[FRAME_WORDS - 1] = good ? csum : csum ^ (16'h1 << $urandom_range(0, 15));
		for (i = 0; i < FRAME_WORDS; i++) begin
			send_byte(words[i][7:0]);
			send_byte(words[i][15:8]);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_word(input logic [swfr_pkg::WORD_W-1:0] v);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sync_word = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_idle_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hCD);
		send_byte(8'h12);
		send_byte(8'hAB);
		send_byte(8'hCD);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'hFF);
		send_byte(8'h00);
		// opens a frame that the next frame start abandons
		send_byte(8'hCD);
		send_byte(8'hAB);
	endtask

	task automatic test_restart_mid_frame();
		send_frame(1'b1, 1'b0, 4);
		drain_results();
	endtask

	task automatic test_start_word_settings();
		write_start_word(16'h5A3C);
	endtask

	task automatic test_checksum_error();
		send_frame(1'b0, 1'b1, -1);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		sync_word = swfr_pkg::START_RESET;
		held_byte = '0;
		fill_level = 0;
		foreach (frame_bytes[i]) frame_bytes[i] = '0;
		mismatches = 0;
		cycle_count = 0;
		stall_left = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_bytes();
		test_restart_mid_frame();
		test_start_word_settings();
		// tail of the run without idling
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_checksum_error();
		drain_results();

		if (mismatches == 0 && expected_words.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
